[src/gsck_pkg.sv]
// Package for the green screen chroma key blend.
// Holds the fixed-point constants, register indexes and shared types.
// Depends on nothing.
package gsck_pkg;

   localparam int unsigned ChanWidth   = 8;
   localparam int unsigned GainWidth   = 13;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned AlphaWidth  = 17;

   // One in the alpha format (16 fraction bits).
   localparam logic [AlphaWidth-1:0] ALPHA_ONE = 17'h10000;

   // floor(p / 255) equals (p * RECIP_255) >> RECIP_SHIFT for p below 2^22.
   localparam logic [23:0] RECIP_255   = 24'h808081;
   localparam int unsigned RECIP_SHIFT = 31;

   localparam logic [GainWidth-1:0] GAIN_RB_RESET = 13'd1024;
   localparam logic [GainWidth-1:0] GAIN_G_RESET  = 13'd1587;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GAIN_RB = 2'd0,
      CSR_GAIN_G  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [ChanWidth-1:0] cam_red;
      logic [ChanWidth-1:0] cam_green;
      logic [ChanWidth-1:0] cam_blue;
      logic [ChanWidth-1:0] back_red;
      logic [ChanWidth-1:0] back_green;
      logic [ChanWidth-1:0] back_blue;
   } pixel_type;

endpackage

[src/green_screen_chroma_key_blend.sv]
// Top level of the green screen chroma key blend: a six-stage pipeline.
// Uses gsck_pkg for constants, register indexes and the pixel type.
//
// One camera pixel and the background pixel at the same place enter as a
// word on the req_ channel; the keyed pixel leaves as a word on rsp_.
// Alpha = 1 + gain_rb*(r+b)/255 - gain_g*g/255, clamped to [0,1] and
// squared; green is despilled to min(g, max(r,b)) before blending.
// Stages: gain products, reciprocal multiply for the /255, alpha sum and
// clamp, alpha squared, blend products, blend sum into the output register.
// rsp_valid rises once the word reaches the output register, the last stage.
// One word is taken every cycle while the receiver does not stall, since
// each stage can load in the same cycle that its word moves on.
// Each stage holds its own valid bit and moves when the next stage is empty
// or moving, so bubbles close up while the receiver stalls and input is
// still taken until every stage is full. Nothing is lost or repeated.
// Reset empties the pipeline and loads the default gains (4.0 and 1587/256).
// The user must write the gains through csr_ only while the pipeline is empty;
// the block does not enforce it. Indexes other than the two gains are ignored.
module green_screen_chroma_key_blend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_cam_red,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_cam_green,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_cam_blue,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_back_red,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_back_green,
   input  logic [gsck_pkg::ChanWidth-1:0]      req_back_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gsck_pkg::ChanWidth-1:0]      rsp_out_red,
   output logic [gsck_pkg::ChanWidth-1:0]      rsp_out_green,
   output logic [gsck_pkg::ChanWidth-1:0]      rsp_out_blue,
   input  logic                                csr_write,
   input  logic [gsck_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [gsck_pkg::GainWidth-1:0]      csr_data
);

   logic [gsck_pkg::GainWidth-1:0] gain_rb_ff;
   logic [gsck_pkg::GainWidth-1:0] gain_g_ff;

   logic [6:1] valid_ff;
   logic [6:1] en;

   // Stage 1: gain products.
   gsck_pkg::pixel_type s1_pix_ff, s1_pix_in;
   logic [21:0]         s1_prb_ff, s1_prb_in;
   logic [20:0]         s1_pg_ff, s1_pg_in;
   logic [8:0]          rb_sum;
   logic [7:0]          rb_max;

   // Stage 2: quotients by 255.
   gsck_pkg::pixel_type s2_pix_ff;
   logic [21:0]         s2_prb_ff;
   logic [20:0]         s2_pg_ff;
   logic [14:0]         s2_qrb_ff, s2_qrb_in;
   logic [14:0]         s2_qg_ff, s2_qg_in;
   logic [45:0]         qrb_full;
   logic [44:0]         qg_full;

   // Stage 3: clamped alpha.
   gsck_pkg::pixel_type              s3_pix_ff;
   logic [gsck_pkg::AlphaWidth-1:0]  s3_alpha_ff, s3_alpha_in;
   logic [22:0]                      t_rb;
   logic [22:0]                      t_g;
   logic signed [24:0]               alpha_raw;

   // Stage 4: alpha squared.
   gsck_pkg::pixel_type              s4_pix_ff;
   logic [gsck_pkg::AlphaWidth-1:0]  s4_a2_ff, s4_a2_in;
   logic [33:0]                      a_sq;

   // Stage 5: blend products.
   logic [24:0] s5_cam_r_ff, s5_cam_g_ff, s5_cam_b_ff;
   logic [24:0] s5_bk_r_ff, s5_bk_g_ff, s5_bk_b_ff;
   logic [gsck_pkg::AlphaWidth-1:0] inv_a2;

   // Stage 6: output register.
   logic [gsck_pkg::ChanWidth-1:0] out_r_ff, out_g_ff, out_b_ff;
   logic [25:0] sum_r, sum_g, sum_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_rb_ff <= gsck_pkg::GAIN_RB_RESET;
         gain_g_ff  <= gsck_pkg::GAIN_G_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gsck_pkg::CSR_GAIN_RB: gain_rb_ff <= csr_data;
            gsck_pkg::CSR_GAIN_G:  gain_g_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or its word moves on.
   always_comb begin
      en[6] = !valid_ff[6] || rsp_ready;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) valid_ff[1] <= req_valid;
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Stage 1 logic: despill green and form the gain products.
   always_comb begin
      rb_sum = {1'b0, req_cam_red} + {1'b0, req_cam_blue};
      rb_max = (req_cam_red > req_cam_blue) ? req_cam_red : req_cam_blue;
      s1_pix_in.cam_red    = req_cam_red;
      s1_pix_in.cam_green  = (req_cam_green < rb_max) ? req_cam_green : rb_max;
      s1_pix_in.cam_blue   = req_cam_blue;
      s1_pix_in.back_red   = req_back_red;
      s1_pix_in.back_green = req_back_green;
      s1_pix_in.back_blue  = req_back_blue;
      s1_prb_in = gain_rb_ff * rb_sum;
      s1_pg_in  = gain_g_ff * req_cam_green;
   end

   // Stage 2 logic: floor(p / 255) by reciprocal multiply.
   always_comb begin
      qrb_full  = s1_prb_ff * gsck_pkg::RECIP_255;
      qg_full   = s1_pg_ff * gsck_pkg::RECIP_255;
      s2_qrb_in = qrb_full[gsck_pkg::RECIP_SHIFT +: 15];
      s2_qg_in  = qg_full[gsck_pkg::RECIP_SHIFT +: 14] == 14'd0 ? 15'd0
                  : {1'b0, qg_full[gsck_pkg::RECIP_SHIFT +: 14]};
   end

   // Stage 3 logic: floor(p * 256 / 255) is p + floor(p / 255).
   always_comb begin
      t_rb = {1'b0, s2_prb_ff} + {8'd0, s2_qrb_ff};
      t_g  = {2'b0, s2_pg_ff} + {8'd0, s2_qg_ff};
      alpha_raw = $signed({2'b00, t_rb}) + $signed({8'd0, gsck_pkg::ALPHA_ONE})
                  - $signed({2'b00, t_g});
      if (alpha_raw < 0) begin
         s3_alpha_in = '0;
      end else if (alpha_raw > $signed({8'd0, gsck_pkg::ALPHA_ONE})) begin
         s3_alpha_in = gsck_pkg::ALPHA_ONE;
      end else begin
         s3_alpha_in = alpha_raw[gsck_pkg::AlphaWidth-1:0];
      end
   end

   // Stage 4 logic.
   always_comb begin
      a_sq     = s3_alpha_ff * s3_alpha_ff;
      s4_a2_in = a_sq[32:16];
   end

   assign inv_a2 = gsck_pkg::ALPHA_ONE - s4_a2_ff;

   // Stage 6 logic: the sum never exceeds 255 in the upper byte.
   always_comb begin
      sum_r = {1'b0, s5_cam_r_ff} + {1'b0, s5_bk_r_ff};
      sum_g = {1'b0, s5_cam_g_ff} + {1'b0, s5_bk_g_ff};
      sum_b = {1'b0, s5_cam_b_ff} + {1'b0, s5_bk_b_ff};
   end

   always_ff @(posedge clock) begin
      if (en[1] && req_valid) begin
         s1_pix_ff <= s1_pix_in;
         s1_prb_ff <= s1_prb_in;
         s1_pg_ff  <= s1_pg_in;
      end
      if (en[2] && valid_ff[1]) begin
         s2_pix_ff <= s1_pix_ff;
         s2_prb_ff <= s1_prb_ff;
         s2_pg_ff  <= s1_pg_ff;
         s2_qrb_ff <= s2_qrb_in;
         s2_qg_ff  <= s2_qg_in;
      end
      if (en[3] && valid_ff[2]) begin
         s3_pix_ff   <= s2_pix_ff;
         s3_alpha_ff <= s3_alpha_in;
      end
      if (en[4] && valid_ff[3]) begin
         s4_pix_ff <= s3_pix_ff;
         s4_a2_ff  <= s4_a2_in;
      end
      if (en[5] && valid_ff[4]) begin
         s5_cam_r_ff <= s4_pix_ff.cam_red    * s4_a2_ff;
         s5_cam_g_ff <= s4_pix_ff.cam_green  * s4_a2_ff;
         s5_cam_b_ff <= s4_pix_ff.cam_blue   * s4_a2_ff;
         s5_bk_r_ff  <= s4_pix_ff.back_red   * inv_a2;
         s5_bk_g_ff  <= s4_pix_ff.back_green * inv_a2;
         s5_bk_b_ff  <= s4_pix_ff.back_blue  * inv_a2;
      end
      if (en[6] && valid_ff[5]) begin
         out_r_ff <= sum_r[23:16];
         out_g_ff <= sum_g[23:16];
         out_b_ff <= sum_b[23:16];
      end
   end

   assign rsp_valid     = valid_ff[6];
   assign rsp_out_red   = out_r_ff;
   assign rsp_out_green = out_g_ff;
   assign rsp_out_blue  = out_b_ff;

endmodule

[test/testbench.sv]
// Self-checking testbench for green_screen_chroma_key_blend.
// Predicts each keyed pixel in fixed point and compares it on rsp_; needs gsck_pkg and
// the block itself.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CW = gsck_pkg::ChanWidth;
   localparam int unsigned GW = gsck_pkg::GainWidth;
   localparam int unsigned IW = gsck_pkg::CsrIdxWidth;

   // Indexes past the two gains; writes to them must be ignored.
   localparam logic [IW-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [IW-1:0] CSR_SPARE_HI = 2'd3;

   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_GUARD = 12;

   typedef struct packed {
      logic [CW-1:0] red;
      logic [CW-1:0] green;
      logic [CW-1:0] blue;
   } keyed_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [CW-1:0] req_cam_red = '0;
   logic [CW-1:0] req_cam_green = '0;
   logic [CW-1:0] req_cam_blue = '0;
   logic [CW-1:0] req_back_red = '0;
   logic [CW-1:0] req_back_green = '0;
   logic [CW-1:0] req_back_blue = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CW-1:0] rsp_out_red;
   logic [CW-1:0] rsp_out_green;
   logic [CW-1:0] rsp_out_blue;
   logic          csr_write = 1'b0;
   logic [IW-1:0] csr_index = '0;
   logic [GW-1:0] csr_data = '0;

   green_screen_chroma_key_blend dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cam_red    (req_cam_red),
      .req_cam_green  (req_cam_green),
      .req_cam_blue   (req_cam_blue),
      .req_back_red   (req_back_red),
      .req_back_green (req_back_green),
      .req_back_blue  (req_back_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   gsck_pkg::pixel_type pending_pixels[$];
   keyed_type           keyed_expect[$];
   gsck_pkg::pixel_type held_pixel;

   logic [GW-1:0] gain_rb_now = gsck_pkg::GAIN_RB_RESET;
   logic [GW-1:0] gain_g_now  = gsck_pkg::GAIN_G_RESET;

   int unsigned words_queued = 0;
   int unsigned words_keyed  = 0;
   int unsigned mismatches   = 0;
   int unsigned idle_cycles  = 0;
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned seg_left     = 0;
   logic        seg_ready    = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [CW-1:0] blend_chan(logic [CW-1:0] cam, logic [CW-1:0] back,
                                                longint unsigned a2);
      longint unsigned mix;
      mix = 64'(cam) * a2 + 64'(back) * (64'(gsck_pkg::ALPHA_ONE) - a2);
      return mix[16 +: CW];
   endfunction

   function automatic keyed_type key_pixel(gsck_pkg::pixel_type p, logic [GW-1:0] rb_gain,
                                           logic [GW-1:0] g_gain);
      longint unsigned rb_term;
      longint unsigned g_term;
      longint unsigned a2;
      longint          alpha;
      logic [CW-1:0]   brightest;
      logic [CW-1:0]   despilled;
      keyed_type       k;
      rb_term = 64'(rb_gain) * (64'(p.cam_red) + 64'(p.cam_blue)) * 256 / 255;
      g_term  = 64'(g_gain) * 64'(p.cam_green) * 256 / 255;
      alpha   = longint'(gsck_pkg::ALPHA_ONE) + longint'(rb_term) - longint'(g_term);
      if (alpha > longint'(gsck_pkg::ALPHA_ONE)) begin
         alpha = longint'(gsck_pkg::ALPHA_ONE);
      end else if (alpha < 0) begin
         alpha = 0;
      end
      a2 = (64'(alpha) * 64'(alpha)) >> 16;
      brightest = (p.cam_red > p.cam_blue) ? p.cam_red : p.cam_blue;
      despilled = (p.cam_green < brightest) ? p.cam_green : brightest;
      k.red   = blend_chan(p.cam_red, p.back_red, a2);
      k.green = blend_chan(despilled, p.back_green, a2);
      k.blue  = blend_chan(p.cam_blue, p.back_blue, a2);
      return k;
   endfunction

   task automatic queue_pixel(input int r, input int g, input int b,
                              input int br, input int bg, input int bb);
      gsck_pkg::pixel_type p;
      p.cam_red    = CW'(r);
      p.cam_green  = CW'(g);
      p.cam_blue   = CW'(b);
      p.back_red   = CW'(br);
      p.back_green = CW'(bg);
      p.back_blue  = CW'(bb);
      pending_pixels.push_back(p);
      words_queued++;
   endtask

   // Mostly realistic footage: green backdrop, foreground, and pixels near the
   // edge of the key where alpha can land between zero and one.
   task automatic queue_random();
      int style;
      int r;
      int g;
      int b;
      int sum;
      style = $urandom_range(0, 99);
      g = $urandom_range(0, 255);
      if (style < 30) begin
         r = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
      end else if (style < 55) begin
         g = $urandom_range(140, 255);
         r = $urandom_range(0, 90);
         b = $urandom_range(0, 90);
      end else if (style < 70 || gain_rb_now == 0) begin
         r = $urandom_range(90, 255);
         b = $urandom_range(60, 255);
      end else begin
         sum = int'(gain_g_now) * g / int'(gain_rb_now) + $urandom_range(0, 60) - 45;
         if (sum < 0) sum = 0;
         if (sum > 510) sum = 510;
         r = $urandom_range((sum > 255) ? sum - 255 : 0, (sum < 255) ? sum : 255);
         b = sum - r;
      end
      queue_pixel(r, g, b, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
   endtask

   task automatic wait_drained();
      while (words_keyed != words_queued) @(negedge clock);
   endtask

   task automatic write_gain(input logic [IW-1:0] idx, input logic [GW-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == gsck_pkg::CSR_GAIN_RB) begin
         gain_rb_now = value;
      end else if (idx == gsck_pkg::CSR_GAIN_G) begin
         gain_g_now = value;
      end
   endtask

   task automatic key_phase(input logic [GW-1:0] rb_gain, input logic [GW-1:0] g_gain,
                            input int count);
      wait_drained();
      write_gain(gsck_pkg::CSR_GAIN_RB, rb_gain);
      write_gain(gsck_pkg::CSR_GAIN_G, g_gain);
      for (int i = 0; i < count; i++) queue_random();
   endtask

   // Driver: sends pending words in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            keyed_expect.push_back(key_pixel(held_pixel, gain_rb_now, gain_g_now));
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               held_pixel = pending_pixels.pop_front();
               req_cam_red    <= held_pixel.cam_red;
               req_cam_green  <= held_pixel.cam_green;
               req_cam_blue   <= held_pixel.cam_blue;
               req_back_red   <= held_pixel.back_red;
               req_back_green <= held_pixel.back_green;
               req_back_blue  <= held_pixel.back_blue;
               req_valid      <= 1'b1;
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every keyed word and stalls in alternating segments.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_keyed++;
            if (keyed_expect.size() == 0) begin
               $error("keyed word with no expectation waiting");
               mismatches++;
            end else begin
               keyed_type k;
               k = keyed_expect.pop_front();
               if (rsp_out_red !== k.red) begin
                  $error("out_red: expected %0d, actual %0d", k.red, rsp_out_red);
                  mismatches++;
               end
               if (rsp_out_green !== k.green) begin
                  $error("out_green: expected %0d, actual %0d", k.green, rsp_out_green);
                  mismatches++;
               end
               if (rsp_out_blue !== k.blue) begin
                  $error("out_blue: expected %0d, actual %0d", k.blue, rsp_out_blue);
                  mismatches++;
               end
            end
         end
         if (seg_left == 0) begin
            seg_ready = ~seg_ready;
            if (seg_ready) begin
               seg_left = $urandom_range(1, 50);
            end else begin
               seg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6);
            end
         end
         seg_left = seg_left - 1;
         rsp_ready <= seg_ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset gains first, with the corners of the key.
      queue_pixel(0, 0, 0, 255, 255, 255);
      queue_pixel(255, 255, 255, 0, 0, 0);
      queue_pixel(0, 255, 0, 12, 200, 99);
      queue_pixel(0, 255, 0, 255, 255, 255);
      queue_pixel(0, 255, 0, 0, 0, 0);
      queue_pixel(255, 0, 0, 40, 80, 120);
      queue_pixel(0, 0, 255, 200, 10, 30);
      queue_pixel(100, 180, 60, 77, 66, 55);
      queue_pixel(200, 230, 150, 10, 250, 20);
      queue_pixel(80, 100, 70, 255, 0, 255);
      queue_pixel(40, 100, 60, 0, 255, 0);
      queue_pixel(128, 128, 128, 1, 2, 3);
      queue_pixel(170, 85, 170, 85, 170, 85);
      queue_pixel(85, 170, 85, 170, 85, 170);
      queue_pixel(30, 250, 200, 99, 99, 99);
      queue_pixel(255, 255, 0, 128, 64, 32);
      queue_pixel(0, 1, 0, 254, 253, 252);
      queue_pixel(1, 254, 1, 0, 128, 255);
      for (int i = 0; i < 150; i++) queue_random();

      // Zero gains keep alpha at one: camera passes through, despilled. Then each gain at zero or full scale.
      key_phase(13'd0, 13'd0, 60);
      key_phase(13'd8191, 13'd8191, 80);
      key_phase(13'd0, 13'd8191, 60);
      key_phase(13'd8191, 13'd0, 40);

      // Writes to unused indexes must leave both gains alone.
      wait_drained();
      write_gain(gsck_pkg::CSR_GAIN_RB, gsck_pkg::GAIN_RB_RESET);
      write_gain(gsck_pkg::CSR_GAIN_G, gsck_pkg::GAIN_G_RESET);
      write_gain(CSR_SPARE_LO, 13'h1FFF);
      write_gain(CSR_SPARE_HI, 13'h0000);
      write_gain(CSR_SPARE_HI, 13'h1FFF);
      for (int i = 0; i < 100; i++) queue_random();

      for (int p = 0; p < 6; p++) begin
         if (p % 2 == 0) begin
            key_phase(GW'($urandom_range(0, 8191)), GW'($urandom_range(0, 8191)), 75);
         end else begin
            key_phase(GW'($urandom_range(256, 2048)), GW'($urandom_range(512, 3072)), 75);
         end
      end

      wait_drained();
      repeat (DRAIN_GUARD) @(posedge clock);
      if (keyed_expect.size() != 0) begin
         $error("%0d expected keyed words never arrived", keyed_expect.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[green_screen_chroma_key_blend.f]
src/gsck_pkg.sv
src/green_screen_chroma_key_blend.sv
test/testbench.sv
